>>> hdl/csal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csal_pkg
// Shared types and constants of the cubic segment arc length core.
// ----------------------------------------------------------------------------
package csal_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int STEP_W    = 11;
  localparam int T_W       = 17;
  localparam int NUM_W     = STEP_W + 16;
  localparam int CNT_W     = 5;
  localparam int ACC_W     = 38;
  localparam int MUL_A_W   = 38;
  localparam int MUL_B_W   = 34;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = 40;

  localparam logic [7:0] REG_CURVE_KIND = 8'd0;
  localparam logic [7:0] REG_STEP_COUNT = 8'd1;

  localparam logic CURVE_CATMULL_ROM = 1'b0;
  localparam logic CURVE_BEZIER      = 1'b1;

  typedef struct packed {
    logic signed [31:0] point0_x;
    logic signed [31:0] point0_y;
    logic signed [31:0] point0_z;
    logic signed [31:0] point1_x;
    logic signed [31:0] point1_y;
    logic signed [31:0] point1_z;
    logic signed [31:0] point2_x;
    logic signed [31:0] point2_y;
    logic signed [31:0] point2_z;
    logic signed [31:0] point3_x;
    logic signed [31:0] point3_y;
    logic signed [31:0] point3_z;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] arc_length;
    logic             length_saturated;
  } result_t;

endpackage

>>> hdl/csal_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csal_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module csal_mul (
  input  logic                               clk,
  input  logic signed [csal_pkg::MUL_A_W-1:0] a,
  input  logic signed [csal_pkg::MUL_B_W-1:0] b,
  output logic signed [csal_pkg::PROD_W-1:0]  p
);
  import csal_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> hdl/csal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csal_div
// Restoring divider, one quotient bit per cycle, for the sample parameter.
// ----------------------------------------------------------------------------
module csal_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [csal_pkg::NUM_W-1:0]      num,
  input  logic [csal_pkg::STEP_W-1:0]     den,
  output logic                            done,
  output logic [csal_pkg::NUM_W-1:0]      quot
);
  import csal_pkg::*;

  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] d;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [STEP_W:0]   sh;
  logic              take;

  assign sh   = {rem, quot[NUM_W-1]};
  assign take = sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      d    <= den;
    end else if (run) begin
      quot <= {quot[NUM_W-2:0], take};
      rem  <= take ? STEP_W'(sh - {1'b0, d}) : sh[STEP_W-1:0];
    end
  end

endmodule

>>> hdl/csal_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csal_sqrt
// Floored integer square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module csal_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import csal_pkg::*;

  logic [63:0]      v;
  logic [63:0]      res;
  logic [63:0]      bitm;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [63:0]      trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= 64'd1 << 62;
    end else if (run) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

>>> hdl/cubic_spline_segment_arc_length_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_spline_segment_arc_length_core
// Chord-sum arc length of one Catmull-Rom or cubic Bezier segment in 3D.
// ----------------------------------------------------------------------------
// Usage:
//   Write curve_kind (index 0) and step_count (index 1) over the cfg channel
//   while the core is idle; cfg_ready is always high. Present four control
//   points on in and pulse start while busy is low. busy stays high until the
//   result has been shown.
//   The result appears on result, marked by done for exactly one cycle; the
//   receiver must take it then.
// Per step: each of the n steps runs the divide that forms t (start, 27
//   quotient bits, hand-off), four shared multiply/add passes plus a square
//   pass per axis for the three axes, and the square root (start, 32
//   iterations, hand-off). The iterative divider and square root and the
//   single multiplier set the length of each step.
// Items: one at a time; the next start is taken the cycle after done.
// Reset: synchronous; sets curve_kind to Catmull-Rom and step_count to 16
//   and returns the core to idle.
// ----------------------------------------------------------------------------
module cubic_spline_segment_arc_length_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  csal_pkg::in_item_t    in,
  output logic                  done,
  output csal_pkg::result_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [10:0]           cfg_data
);
  import csal_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_DIVW  = 10'b0000000100,
    S_HMUL  = 10'b0000001000,
    S_HADD  = 10'b0000010000,
    S_SQMUL = 10'b0000100000,
    S_SQADD = 10'b0001000000,
    S_ROOT  = 10'b0010000000,
    S_ROOTW = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  logic              curve_kind;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] n_eff;
  logic [STEP_W-1:0] step_i;
  logic [T_W-1:0]    t;
  logic [1:0]        axis;
  logic [1:0]        k;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] coef [3][4];
  logic signed [31:0]      prev [3];
  logic [63:0]       sq;
  logic [SUM_W-1:0]  sum;
  logic              sat;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= CURVE_CATMULL_ROM;
      step_count <= STEP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CURVE_KIND) curve_kind <= cfg_data[0];
      else if (cfg_index == REG_STEP_COUNT) step_count <= cfg_data;
    end
  end

  // coefficients of twice the power-basis polynomial
  logic signed [ACC_W-1:0] q [4][3];
  logic signed [ACC_W-1:0] c_new [3][4];
  logic signed [ACC_W-1:0] cub [3];

  always_comb begin
    q[0][0] = ACC_W'(in.point0_x); q[0][1] = ACC_W'(in.point0_y);
    q[0][2] = ACC_W'(in.point0_z);
    q[1][0] = ACC_W'(in.point1_x); q[1][1] = ACC_W'(in.point1_y);
    q[1][2] = ACC_W'(in.point1_z);
    q[2][0] = ACC_W'(in.point2_x); q[2][1] = ACC_W'(in.point2_y);
    q[2][2] = ACC_W'(in.point2_z);
    q[3][0] = ACC_W'(in.point3_x); q[3][1] = ACC_W'(in.point3_y);
    q[3][2] = ACC_W'(in.point3_z);
    for (int a = 0; a < 3; a++) begin
      cub[a] = -q[0][a] + 3 * q[1][a] - 3 * q[2][a] + q[3][a];
      if (curve_kind == CURVE_CATMULL_ROM) begin
        c_new[a][0] = 2 * q[1][a];
        c_new[a][1] = q[2][a] - q[0][a];
        c_new[a][2] = 2 * q[0][a] - 5 * q[1][a] + 4 * q[2][a] - q[3][a];
        c_new[a][3] = cub[a];
      end else begin
        c_new[a][0] = 2 * q[0][a];
        c_new[a][1] = 6 * (q[1][a] - q[0][a]);
        c_new[a][2] = 6 * (q[0][a] - 2 * q[1][a] + q[2][a]);
        c_new[a][3] = 2 * cub[a];
      end
    end
  end

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_done;
  logic [NUM_W-1:0]          quot;
  logic                      root_done;
  logic [31:0]               root;

  csal_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  csal_div u_div (
    .clk(clk), .rst(rst), .start(state == S_DIV),
    .num({step_i, 16'b0}), .den(n_eff), .done(div_done), .quot(quot)
  );

  csal_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(state == S_ROOT),
    .radicand(sq), .done(root_done), .root(root)
  );

  // datapath around the multiplier
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W:0]    half;
  logic signed [31:0]       cur;
  logic                     clip;
  logic signed [32:0]       diff;
  logic [31:0]              absd;
  logic [64:0]              sq_sum;
  logic [SUM_W:0]           len_sum;

  always_comb begin
    rnd      = (prod + PROD_W'(32768)) >>> 16;
    acc_next = ACC_W'(rnd) + coef[axis][k];
    half     = ((ACC_W+1)'(acc) + (ACC_W+1)'(1)) >>> 1;
    clip     = 1'b0;
    if (half > (ACC_W+1)'(32'sh7fffffff)) begin
      cur  = 32'sh7fffffff;
      clip = 1'b1;
    end else if (half < -(ACC_W+1)'(33'sh080000000)) begin
      cur  = 32'sh80000000;
      clip = 1'b1;
    end else begin
      cur = half[31:0];
    end
    diff = 33'(cur) - 33'(prev[axis]);
    absd = diff[32] ? 32'(-diff) : diff[31:0];
    sq_sum  = {1'b0, sq} + {1'b0, prod[63:0]};
    len_sum = {1'b0, sum} + (SUM_W+1)'(root);
    if (state == S_SQMUL) begin
      mul_a = MUL_A_W'({1'b0, absd});
      mul_b = MUL_B_W'({1'b0, absd});
    end else begin
      mul_a = acc;
      mul_b = MUL_B_W'({1'b0, t});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (start) state <= S_DIV;
        S_DIV:   state <= S_DIVW;
        S_DIVW:  if (div_done) state <= S_HMUL;
        S_HMUL:  state <= S_HADD;
        S_HADD:  state <= (k == 2'd0) ? S_SQMUL : S_HMUL;
        S_SQMUL: state <= S_SQADD;
        S_SQADD: state <= (axis == 2'd2) ? S_ROOT : S_HMUL;
        S_ROOT:  state <= S_ROOTW;
        S_ROOTW: if (root_done) state <= (step_i == n_eff) ? S_DONE : S_DIV;
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 4; j++) coef[a][j] <= c_new[a][j];
          end
          if (curve_kind == CURVE_CATMULL_ROM) begin
            prev[0] <= in.point1_x; prev[1] <= in.point1_y; prev[2] <= in.point1_z;
          end else begin
            prev[0] <= in.point0_x; prev[1] <= in.point0_y; prev[2] <= in.point0_z;
          end
          if (step_count == '0) n_eff <= STEP_W'(1);
          else if (step_count > STEP_W'(MAX_STEPS)) n_eff <= STEP_W'(MAX_STEPS);
          else n_eff <= step_count;
          step_i <= STEP_W'(1);
          sum    <= '0;
          sat    <= 1'b0;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          t    <= quot[T_W-1:0];
          axis <= 2'd0;
          k    <= 2'd3;
          acc  <= '0;
          sq   <= '0;
        end
      end
      S_HADD: begin
        acc <= acc_next;
        if (k != 2'd0) k <= k - 1'b1;
      end
      S_SQMUL: begin
        prev[axis] <= cur;
        if (clip) sat <= 1'b1;
      end
      S_SQADD: begin
        // a carry out means the squared length clipped
        if (sq_sum[64]) begin
          sq  <= '1;
          sat <= 1'b1;
        end else begin
          sq <= sq_sum[63:0];
        end
        axis <= axis + 1'b1;
        k    <= 2'd3;
        acc  <= '0;
      end
      S_ROOTW: begin
        if (root_done) begin
          if (len_sum[SUM_W]) begin
            sum <= '1;
            sat <= 1'b1;
          end else begin
            sum <= len_sum[SUM_W-1:0];
          end
          step_i <= step_i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy                    = (state != S_IDLE);
  assign done                    = (state == S_DONE);
  assign result.arc_length       = sum;
  assign result.length_saturated = sat;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic segment arc length core: a local fixed
// point chord-sum calculator predicts each result, directed corner cases and
// random control points run through several curve and step settings.
// ----------------------------------------------------------------------------
module testbench;
  import csal_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [7:0] REG_PAST_END = 8'd2;
  localparam logic [7:0] REG_TOP      = 8'hFF;
  localparam logic [39:0] LENGTH_MAX  = 40'hFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in = '0;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // register copies kept by the bench
  logic        kind_shadow = CURVE_CATMULL_ROM;
  logic [10:0] steps_shadow = 11'd16;

  result_t     expected_lengths[$];
  int          errors = 0;
  int          items_sent = 0;
  int          lengths_checked = 0;
  int          clipped_seen = 0;
  longint      cycles = 0;
  bit          gaps_on = 1'b1;

  cubic_spline_segment_arc_length_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in        (in),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint eval_axis(input longint c0, input longint c1,
                                       input longint c2, input longint c3,
                                       input longint t, inout bit clipped);
    longint acc;
    acc = c3;
    acc = ((acc * t + 32768) >>> 16) + c2;
    acc = ((acc * t + 32768) >>> 16) + c1;
    acc = ((acc * t + 32768) >>> 16) + c0;
    acc = (acc + 1) >>> 1;
    if (acc > 64'sd2147483647) begin
      clipped = 1'b1;
      acc = 64'sd2147483647;
    end else if (acc < -64'sd2147483648) begin
      clipped = 1'b1;
      acc = -64'sd2147483648;
    end
    return acc;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic result_t predict_length(input in_item_t it, input logic kind,
                                             input logic [10:0] steps_reg);
    longint p[4][3];
    longint c[3][4];
    longint prev[3];
    longint cub, t, cur, d;
    logic [63:0] n, mag, sq, sum;
    logic [64:0] wide;
    bit clipped;
    result_t r;
    clipped = 1'b0;
    sum = '0;
    n = 64'(steps_reg);
    if (n == 0) n = 64'd1;
    if (n > MAX_STEPS) n = 64'(MAX_STEPS);
    p[0][0] = it.point0_x; p[0][1] = it.point0_y; p[0][2] = it.point0_z;
    p[1][0] = it.point1_x; p[1][1] = it.point1_y; p[1][2] = it.point1_z;
    p[2][0] = it.point2_x; p[2][1] = it.point2_y; p[2][2] = it.point2_z;
    p[3][0] = it.point3_x; p[3][1] = it.point3_y; p[3][2] = it.point3_z;
    for (int a = 0; a < 3; a++) begin
      cub = -p[0][a] + 3 * p[1][a] - 3 * p[2][a] + p[3][a];
      if (kind == CURVE_CATMULL_ROM) begin
        c[a][0] = 2 * p[1][a];
        c[a][1] = p[2][a] - p[0][a];
        c[a][2] = 2 * p[0][a] - 5 * p[1][a] + 4 * p[2][a] - p[3][a];
        c[a][3] = cub;
        prev[a] = p[1][a];
      end else begin
        c[a][0] = 2 * p[0][a];
        c[a][1] = 6 * (p[1][a] - p[0][a]);
        c[a][2] = 6 * (p[0][a] - 2 * p[1][a] + p[2][a]);
        c[a][3] = 2 * cub;
        prev[a] = p[0][a];
      end
    end
    for (longint i = 1; i <= longint'(n); i++) begin
      t = (i * 65536) / longint'(n);
      sq = '0;
      for (int a = 0; a < 3; a++) begin
        cur = eval_axis(c[a][0], c[a][1], c[a][2], c[a][3], t, clipped);
        d = cur - prev[a];
        mag = (d < 0) ? -d : d;
        wide = {1'b0, sq} + {1'b0, mag * mag};
        if (wide[64]) begin
          sq = '1;
          clipped = 1'b1;
        end else begin
          sq = wide[63:0];
        end
        prev[a] = cur;
      end
      sum = sum + int_sqrt(sq);
      if (sum > LENGTH_MAX) begin
        sum = LENGTH_MAX;
        clipped = 1'b1;
      end
    end
    r.arc_length = sum[39:0];
    r.length_saturated = clipped;
    return r;
  endfunction

  // ------------------------------------------------- input and config monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CURVE_KIND) kind_shadow <= cfg_data[0];
      else if (cfg_index == REG_STEP_COUNT) steps_shadow <= cfg_data;
    end
    if (!rst && start && !busy) begin
      expected_lengths.push_back(predict_length(in, kind_shadow, steps_shadow));
      items_sent <= items_sent + 1;
    end
  end

  // ------------------------------------------------------------ result check
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_lengths.size() == 0) begin
        $display("%0t: unexpected result beat, actual length %h sat %b", $time,
                 result.arc_length, result.length_saturated);
        errors <= errors + 1;
      end else begin
        want = expected_lengths.pop_front();
        lengths_checked <= lengths_checked + 1;
        if (want.length_saturated) clipped_seen <= clipped_seen + 1;
        if (result.arc_length !== want.arc_length) begin
          $display("%0t: arc_length expected %h actual %h", $time,
                   want.arc_length, result.arc_length);
          errors <= errors + 1;
        end
        if (result.length_saturated !== want.length_saturated) begin
          $display("%0t: length_saturated expected %b actual %b", $time,
                   want.length_saturated, result.length_saturated);
          errors <= errors + 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  task automatic send_points(input in_item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // start may already be high from the previous beat when there is no gap
    start <= 1'b1;
    in <= it;
    do @(posedge clk); while (!(start && !busy));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(input int style);
    case (style)
      0: return $urandom();
      1: return 32'($urandom_range(0, 2 ** 21) - 2 ** 20);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_points(input int style);
    in_item_t it;
    logic [383:0] flat;
    for (int k = 0; k < 12; k++) flat[k*32 +: 32] = pick_coord(style);
    it = flat;
    return it;
  endfunction

  function automatic in_item_t fill_points(input logic [31:0] a, input logic [31:0] b);
    in_item_t it;
    it.point0_x = a; it.point0_y = a; it.point0_z = a;
    it.point1_x = b; it.point1_y = b; it.point1_z = b;
    it.point2_x = a; it.point2_y = a; it.point2_z = a;
    it.point3_x = b; it.point3_y = b; it.point3_z = b;
    return it;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_field_extremes();
    in_item_t it;
    for (int kind = 0; kind < 2; kind++) begin
      write_reg(REG_CURVE_KIND, kind[10:0]);
      write_reg(REG_STEP_COUNT, 11'd1);
      send_points(fill_points(32'h0, 32'h0));
      send_points(fill_points(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_points(fill_points(32'h8000_0000, 32'h8000_0000));
      // opposite corners overflow the squared chord
      send_points(fill_points(32'h8000_0000, 32'h7FFF_FFFF));
      send_points(fill_points(32'h7FFF_FFFF, 32'h8000_0000));
      it = fill_points(32'h8000_0000, 32'h8000_0000);
      it.point3_x = 32'h7FFF_FFFF; it.point3_y = 32'h7FFF_FFFF;
      it.point3_z = 32'h7FFF_FFFF;
      send_points(it);
      wait_idle();
      // wild control points push samples out of range
      write_reg(REG_STEP_COUNT, 11'd7);
      send_points(fill_points(32'h7FFF_FFFF, 32'h8000_0000));
      send_points(fill_points(32'h0001_0000, 32'hFFFF_0000));
      wait_idle();
    end
  endtask

  task automatic test_step_limits();
    in_item_t it;
    it = fill_points(32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(REG_CURVE_KIND, {10'h3FF, CURVE_CATMULL_ROM});
    write_reg(REG_STEP_COUNT, 11'd0);
    send_points(it);
    send_points(random_points(1));
    wait_idle();
    write_reg(REG_STEP_COUNT, 11'd2);
    send_points(random_points(1));
    wait_idle();
    write_reg(REG_STEP_COUNT, 11'd1024);
    send_points(it);
    wait_idle();
    write_reg(REG_CURVE_KIND, {10'h0, CURVE_BEZIER});
    write_reg(REG_STEP_COUNT, 11'd2047);
    send_points(random_points(0));
    wait_idle();
  endtask

  task automatic test_unused_index();
    write_reg(REG_CURVE_KIND, {10'h0, CURVE_BEZIER});
    write_reg(REG_STEP_COUNT, 11'd3);
    write_reg(REG_PAST_END, 11'h7FF);
    write_reg(REG_TOP, 11'h000);
    send_points(random_points(1));
    send_points(random_points(2));
    wait_idle();
  endtask

  task automatic test_random_segments();
    logic [10:0] steps;
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on = (phase % 3) != 1;
      case (phase)
        2: steps = 11'd0;
        5: steps = 11'd1;
        7: steps = 11'($urandom_range(32, 64));
        default: steps = 11'($urandom_range(1, 16));
      endcase
      write_reg(REG_CURVE_KIND, 11'($urandom_range(0, 1)));
      write_reg(REG_STEP_COUNT, steps);
      repeat (phase == 7 ? 30 : 65) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_points(random_points(0));
          3: send_points(random_points(2));
          default: send_points(random_points(1));
        endcase
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_step_limits();
    test_unused_index();
    test_random_segments();
    $display("%0d segments sent, %0d lengths checked, %0d of them clipped",
             items_sent, lengths_checked, clipped_seen);
    $display("both curve kinds, step counts 0 to 2047, unused register indexes");
    if (errors == 0 && expected_lengths.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d lengths never arrived", errors,
               expected_lengths.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> cubic_spline_segment_arc_length_core.f
hdl/csal_pkg.sv
hdl/csal_mul.sv
hdl/csal_div.sv
hdl/csal_sqrt.sv
hdl/cubic_spline_segment_arc_length_core.sv
tb/testbench.sv
